/* design/texture_mip_layout_address_macros.svh */
// Assertion macros shared by the texture mip layout checker.
// No dependencies; include by bare file name.
`ifndef TEXTURE_MIP_LAYOUT_ADDRESS_MACROS_SVH
`define TEXTURE_MIP_LAYOUT_ADDRESS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMLA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/tmla_pkg.sv */
// Types, codes and helper functions for the texture mip layout address block.
// No dependencies; compile first.
package tmla_pkg;

	localparam int DIM_W    = 15;
	localparam int IMG_W    = 16;
	localparam int MIP_W    = 4;
	localparam int ROW_W    = 19;
	localparam int PLANE_W  = 33;
	localparam int BYTE_W   = 48;
	localparam int HALF_W   = BYTE_W / 2;
	localparam int ROWX_W   = 20;   // row pitch before output truncation
	localparam int PLX_W    = 35;   // plane pitch before output truncation
	localparam int PB_W     = 5;
	localparam int FK_W     = 2;
	localparam int CK_W     = 4;
	localparam int ST_W     = 2;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int REG_W    = 3;
	localparam int SHIFT_W  = 5;

	localparam int MAX_DIM  = 16384;
	localparam int MAX_PB   = 16;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD_CFG = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD_MIP = 2'd2;

	localparam logic [FK_W-1:0] FK_RAW   = 2'd0;
	localparam logic [FK_W-1:0] FK_BLOCK = 2'd1;

	localparam logic [CK_W-1:0] CK_BC1  = 4'd0;
	localparam logic [CK_W-1:0] CK_BC1A = 4'd1;
	localparam logic [CK_W-1:0] CK_BC2  = 4'd2;
	localparam logic [CK_W-1:0] CK_BC3  = 4'd3;
	localparam logic [CK_W-1:0] CK_BC4  = 4'd4;
	localparam logic [CK_W-1:0] CK_BC4S = 4'd5;
	localparam logic [CK_W-1:0] CK_BC5  = 4'd6;
	localparam logic [CK_W-1:0] CK_BC5S = 4'd7;

	localparam logic [REG_W-1:0] REG_BASE_WIDTH  = 3'd0;
	localparam logic [REG_W-1:0] REG_BASE_HEIGHT = 3'd1;
	localparam logic [REG_W-1:0] REG_BASE_DEPTH  = 3'd2;
	localparam logic [REG_W-1:0] REG_MIP_LEVELS  = 3'd3;
	localparam logic [REG_W-1:0] REG_FORMAT_KIND = 3'd4;
	localparam logic [REG_W-1:0] REG_COMPRESSION = 3'd5;
	localparam logic [REG_W-1:0] REG_PIXEL_BYTES = 3'd6;

	typedef struct packed {
		logic [DIM_W-1:0] base_width;
		logic [DIM_W-1:0] base_height;
		logic [DIM_W-1:0] base_depth;
		logic [MIP_W-1:0] mip_levels;
		logic [FK_W-1:0]  format_kind;
		logic [CK_W-1:0]  compression_kind;
		logic [PB_W-1:0]  pixel_bytes;
	} cfg_t;

	typedef struct packed {
		logic [DIM_W-1:0]   w;
		logic [DIM_W-1:0]   h;
		logic [DIM_W-1:0]   d;
		logic [ROW_W-1:0]   row;
		logic [PLANE_W-1:0] plane;
		logic [BYTE_W-1:0]  bytes;
		logic [BYTE_W-1:0]  offset;
	} lvl_entry_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		lvl_entry_t        ent;
		logic [BYTE_W-1:0] total;
	} item_t;

	// Dimension of a level: shift right, never below one.
	function automatic logic [DIM_W-1:0] shrink(input logic [DIM_W-1:0] v,
		input logic [SHIFT_W-1:0] lvl);
		logic [DIM_W-1:0] r;
		r = v >> lvl;
		return (r == '0) ? DIM_W'(1) : r;
	endfunction

	// Bytes per 4x4 block; zero for unknown codes.
	function automatic logic [PB_W-1:0] block_bytes(input logic [CK_W-1:0] ck);
		logic [PB_W-1:0] r;
		case (ck)
			CK_BC1, CK_BC1A, CK_BC4, CK_BC4S: r = PB_W'(8);
			CK_BC2, CK_BC3, CK_BC5, CK_BC5S:  r = PB_W'(16);
			default:                          r = '0;
		endcase
		return r;
	endfunction

endpackage

/* design/tmla_if.sv */
// Request and response channel interfaces of the texture mip layout block.
// Depends on tmla_pkg.
interface tmla_req_if import tmla_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IMG_W-1:0] image_index;
	logic [MIP_W-1:0] mip_level;

	modport source (output valid, output image_index, output mip_level, input ready);
	modport sink   (input valid, input image_index, input mip_level, output ready);
endinterface

interface tmla_rsp_if import tmla_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ST_W-1:0]    status;
	logic [BYTE_W-1:0]  byte_offset;
	logic [DIM_W-1:0]   level_width;
	logic [DIM_W-1:0]   level_height;
	logic [DIM_W-1:0]   level_depth;
	logic [ROW_W-1:0]   row_pitch;
	logic [PLANE_W-1:0] plane_pitch;
	logic [BYTE_W-1:0]  level_bytes;
	logic [BYTE_W-1:0]  image_bytes;

	modport source (output valid, output status, output byte_offset, output level_width,
		output level_height, output level_depth, output row_pitch, output plane_pitch,
		output level_bytes, output image_bytes, input ready);
	modport sink (input valid, input status, input byte_offset, input level_width,
		input level_height, input level_depth, input row_pitch, input plane_pitch,
		input level_bytes, input image_bytes, output ready);
endinterface

/* design/texture_mip_layout_address.sv */
// Texture mip layout address generator: image index and mip level in, offset,
// level geometry, pitches and sizes out, through a 4-stage pipe that takes one
// beat per cycle unless rsp.ready is low or a table rebuild holds req.ready low.
// Reset and every config write hold req.ready low through the table rebuild, which
// walks mip_levels levels (MAX_LEVELS levels if mip_levels is 0), plus the rest
// of a walk already running. Depends on tmla_pkg, tmla_if and tmla_layout_table.
module texture_mip_layout_address import tmla_pkg::*; #(
	parameter int MAX_LEVELS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	tmla_req_if.sink          req,
	tmla_rsp_if.source        rsp
);

	localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

	// Configuration registers.
	cfg_t cfg_q;
	logic pend_q;
	logic cfg_wr;
	logic [REG_W-1:0] reg_idx;

	// Layout table.
	logic              tbl_busy, tbl_start, cfg_ok;
	lvl_entry_t        rd_ent;
	logic [BYTE_W-1:0] img_total;

	// Pipeline.
	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	logic              rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	item_t             item_n, item_s1, item_s2, item_s3, item_s4;
	logic [IMG_W-1:0]  img_n, img_s1;
	logic [IMG_W+HALF_W-1:0] pp_lo_s2, pp_hi_s2;
	logic [BYTE_W-1:0] prod_s3, off_s4;
	logic              acc;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{base_width: DIM_W'(1), base_height: '0, base_depth: '0,
				mip_levels: MIP_W'(1), format_kind: FK_RAW, compression_kind: CK_BC1,
				pixel_bytes: PB_W'(4)};
			pend_q <= 1'b1;
		end else begin
			if (cfg_wr) begin
				case (reg_idx)
					REG_BASE_WIDTH:  cfg_q.base_width <= pwdata[DIM_W-1:0];
					REG_BASE_HEIGHT: cfg_q.base_height <= pwdata[DIM_W-1:0];
					REG_BASE_DEPTH:  cfg_q.base_depth <= pwdata[DIM_W-1:0];
					REG_MIP_LEVELS:  cfg_q.mip_levels <= pwdata[MIP_W-1:0];
					REG_FORMAT_KIND: cfg_q.format_kind <= pwdata[FK_W-1:0];
					REG_COMPRESSION: cfg_q.compression_kind <= pwdata[CK_W-1:0];
					REG_PIXEL_BYTES: cfg_q.pixel_bytes <= pwdata[PB_W-1:0];
					default: ;
				endcase
			end
			// Any write invalidates the table; hold requests until it is rebuilt.
			if (cfg_wr) begin
				pend_q <= 1'b1;
			end else if (tbl_start) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BASE_WIDTH:  prdata = DATA_W'(cfg_q.base_width);
			REG_BASE_HEIGHT: prdata = DATA_W'(cfg_q.base_height);
			REG_BASE_DEPTH:  prdata = DATA_W'(cfg_q.base_depth);
			REG_MIP_LEVELS:  prdata = DATA_W'(cfg_q.mip_levels);
			REG_FORMAT_KIND: prdata = DATA_W'(cfg_q.format_kind);
			REG_COMPRESSION: prdata = DATA_W'(cfg_q.compression_kind);
			REG_PIXEL_BYTES: prdata = DATA_W'(cfg_q.pixel_bytes);
			default:         prdata = '0;
		endcase
	end

	assign tbl_start = pend_q && !tbl_busy;

	tmla_layout_table #(
		.MAX_LEVELS(MAX_LEVELS),
		.LVL_W(LVL_W)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.start(tbl_start),
		.busy(tbl_busy),
		.cfg_ok(cfg_ok),
		.rd_lvl(LVL_W'(req.mip_level)),
		.rd_ent(rd_ent),
		.total(img_total)
	);

	// Each stage advances when its slot is empty or the next one moves, so
	// bubbles fill in even while the response is stalled.
	assign rdy_s4 = !vld_s4 || rsp.ready;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign req.ready = rdy_s1 && !pend_q && !tbl_busy;
	assign acc = req.valid && req.ready;

	// Stage 1 input: classify and fetch the level entry. Errors drop every
	// payload field to zero so the later math yields zero as well.
	always_comb begin
		item_n.ent = rd_ent;
		item_n.total = img_total;
		img_n = req.image_index;
		if (!cfg_ok) begin
			item_n.status = ST_BAD_CFG;
		end else if (req.mip_level >= cfg_q.mip_levels) begin
			item_n.status = ST_BAD_MIP;
		end else begin
			item_n.status = ST_OK;
		end
		if (item_n.status != ST_OK) begin
			item_n.ent = '0;
			item_n.total = '0;
			img_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= acc;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= item_n;
			img_s1 <= img_n;
		end
		// Split image_index * image_bytes into two 16x24 partial products.
		if (rdy_s2 && vld_s1) begin
			item_s2 <= item_s1;
			pp_lo_s2 <= (IMG_W + HALF_W)'(img_s1) * (IMG_W + HALF_W)'(item_s1.total[HALF_W-1:0]);
			pp_hi_s2 <= (IMG_W + HALF_W)'(img_s1) *
				(IMG_W + HALF_W)'(item_s1.total[BYTE_W-1:HALF_W]);
		end
		// Combine partial products, wrapping at 48 bits.
		if (rdy_s3 && vld_s2) begin
			item_s3 <= item_s2;
			prod_s3 <= BYTE_W'(pp_lo_s2) + BYTE_W'({pp_hi_s2, {HALF_W{1'b0}}});
		end
		// Add the offset of the lower levels.
		if (rdy_s4 && vld_s3) begin
			item_s4 <= item_s3;
			off_s4 <= prod_s3 + item_s3.ent.offset;
		end
	end

	assign rsp.valid        = vld_s4;
	assign rsp.status       = item_s4.status;
	assign rsp.byte_offset  = off_s4;
	assign rsp.level_width  = item_s4.ent.w;
	assign rsp.level_height = item_s4.ent.h;
	assign rsp.level_depth  = item_s4.ent.d;
	assign rsp.row_pitch    = item_s4.ent.row;
	assign rsp.plane_pitch  = item_s4.ent.plane;
	assign rsp.level_bytes  = item_s4.ent.bytes;
	assign rsp.image_bytes  = item_s4.total;

endmodule

/* design/tmla_layout_table.sv */
// Per-level layout table: a sequencer walks the mip chain after each start and
// stores geometry, sizes and running offsets. Depends on tmla_pkg.
module tmla_layout_table import tmla_pkg::*; #(
	parameter int MAX_LEVELS = 15,
	parameter int LVL_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             start,
	output logic             busy,
	output logic             cfg_ok,
	input  logic [LVL_W-1:0] rd_lvl,
	output lvl_entry_t       rd_ent,
	output logic [BYTE_W-1:0] total
);

	localparam int CMP_W = ((LVL_W > MIP_W) ? LVL_W : MIP_W) + 1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_GEOM  = 2'd1;
	localparam logic [1:0] S_PLANE = 2'd2;
	localparam logic [1:0] S_BYTES = 2'd3;

	logic [1:0]        state_q;
	logic [LVL_W-1:0]  lvl_q;
	logic              cfg_ok_q;
	logic [DIM_W-1:0]  w_q, h_q, d_q, hr_q;
	logic [ROWX_W-1:0] row_q;
	logic [PLX_W-1:0]  plane_q;
	logic [BYTE_W-1:0] total_q;
	lvl_entry_t        tbl_q [MAX_LEVELS];

	logic [DIM_W-1:0]  w_n, h_n, d_n, hr_n, maxd;
	logic [DIM_W:0]    wb, hb;
	logic [ROWX_W-1:0] row_n;
	logic [PLX_W-1:0]  plane_n;
	logic [BYTE_W-1:0] bytes_n;
	logic              ok_n, last;

	// Configuration sanity, held in a register since it only moves on writes.
	always_comb begin
		maxd = cfg.base_width;
		if (cfg.base_height > maxd) maxd = cfg.base_height;
		if (cfg.base_depth > maxd) maxd = cfg.base_depth;
		ok_n = 1'b1;
		if (cfg.base_width == '0 || 32'(cfg.base_width) > MAX_DIM) ok_n = 1'b0;
		if (32'(cfg.base_height) > MAX_DIM || 32'(cfg.base_depth) > MAX_DIM) ok_n = 1'b0;
		if (cfg.base_height == '0 && cfg.base_depth != '0) ok_n = 1'b0;
		if (cfg.mip_levels == '0 || 32'(cfg.mip_levels) > MAX_LEVELS) ok_n = 1'b0;
		if (cfg.format_kind == FK_RAW &&
			(cfg.pixel_bytes == '0 || 32'(cfg.pixel_bytes) > MAX_PB)) ok_n = 1'b0;
		if ((maxd >> (cfg.mip_levels - MIP_W'(1))) == '0) ok_n = 1'b0;
	end

	// Level geometry, row pitch, plane pitch, level bytes and the last-level flag.
	always_comb begin
		w_n = shrink(cfg.base_width, SHIFT_W'(lvl_q));
		h_n = shrink(cfg.base_height, SHIFT_W'(lvl_q));
		d_n = shrink(cfg.base_depth, SHIFT_W'(lvl_q));
		wb = (DIM_W + 1)'(w_n) + (DIM_W + 1)'(3);
		hb = (DIM_W + 1)'(h_n) + (DIM_W + 1)'(3);
		case (cfg.format_kind)
			FK_RAW: begin
				row_n = ROWX_W'(w_n) * ROWX_W'(cfg.pixel_bytes);
				hr_n = h_n;
			end
			FK_BLOCK: begin
				row_n = ROWX_W'(wb[DIM_W:2]) * ROWX_W'(block_bytes(cfg.compression_kind));
				hr_n = DIM_W'(hb[DIM_W:2]);
			end
			default: begin
				row_n = '0;
				hr_n = '0;
			end
		endcase
		plane_n = PLX_W'(row_q) * PLX_W'(hr_q);
		bytes_n = BYTE_W'(plane_q) * BYTE_W'(d_q);
		last = (lvl_q == LVL_W'(MAX_LEVELS - 1)) ||
			(CMP_W'(lvl_q) + CMP_W'(1) == CMP_W'(cfg.mip_levels));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lvl_q <= '0;
			cfg_ok_q <= 1'b0;
		end else begin
			cfg_ok_q <= ok_n;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_GEOM;
						lvl_q <= '0;
					end
				end
				S_GEOM:  state_q <= S_PLANE;
				S_PLANE: state_q <= S_BYTES;
				S_BYTES: begin
					if (last) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_GEOM;
						lvl_q <= lvl_q + LVL_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) total_q <= '0;
		if (state_q == S_GEOM) begin
			w_q <= w_n;
			h_q <= h_n;
			d_q <= d_n;
			row_q <= row_n;
			hr_q <= hr_n;
		end
		if (state_q == S_PLANE) plane_q <= plane_n;
		if (state_q == S_BYTES) begin
			tbl_q[lvl_q] <= '{w: w_q, h: h_q, d: d_q, row: ROW_W'(row_q),
				plane: PLANE_W'(plane_q), bytes: bytes_n, offset: total_q};
			total_q <= total_q + bytes_n;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign cfg_ok = cfg_ok_q;
	assign total  = total_q;
	assign rd_ent = (32'(rd_lvl) < MAX_LEVELS) ? tbl_q[rd_lvl] : '0;

endmodule

/* design/tmla_checker.sv */
// Port-level checker for texture_mip_layout_address, attached by bind.
// Depends on tmla_pkg and texture_mip_layout_address_macros.svh.
`include "texture_mip_layout_address_macros.svh"

module tmla_checker import tmla_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic               pready,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [ST_W-1:0]    status,
	input logic [BYTE_W-1:0]  byte_offset,
	input logic [DIM_W-1:0]   level_width,
	input logic [DIM_W-1:0]   level_height,
	input logic [DIM_W-1:0]   level_depth,
	input logic [ROW_W-1:0]   row_pitch,
	input logic [PLANE_W-1:0] plane_pitch,
	input logic [BYTE_W-1:0]  level_bytes,
	input logic [BYTE_W-1:0]  image_bytes
);

	logic cfg_wr, stalled, err_beat, ok_beat, fields_zero, dims_set, payload_held;
	logic [ST_W+3*BYTE_W+DIM_W-1:0] beat_now, beat_q;

	assign cfg_wr   = psel && penable && pwrite && pready;
	assign stalled  = rsp_valid && !rsp_ready;
	assign err_beat = rsp_valid && (status != ST_OK);
	assign ok_beat  = rsp_valid && (status == ST_OK);
	assign fields_zero = (byte_offset == '0) && (level_width == '0) && (level_height == '0) &&
		(level_depth == '0) && (row_pitch == '0) && (plane_pitch == '0) &&
		(level_bytes == '0) && (image_bytes == '0);
	assign dims_set = (level_width != '0) && (level_height != '0) && (level_depth != '0);

	// Keep last cycle's status, offset, sizes and width to see that a stalled beat holds.
	assign beat_now = {status, byte_offset, level_bytes, image_bytes, level_width};
	always_ff @(posedge clk) begin
		beat_q <= beat_now;
	end
	assign payload_held = (beat_now == beat_q);

	`TMLA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, stalled, rsp_valid && payload_held, "rsp dropped")
	`TMLA_ASSERT_NOW(a_err_zero, clk, arst_n, err_beat, fields_zero, "error beat not zeroed")
	`TMLA_ASSERT_NOW(a_ok_dims, clk, arst_n, ok_beat, dims_set, "ok beat with zero dimension")
	`TMLA_ASSERT_NEXT(a_rebuild, clk, arst_n, cfg_wr, !req_ready, "req taken during rebuild")

endmodule

bind texture_mip_layout_address tmla_checker u_tmla_checker (
	.clk(clk),
	.arst_n(arst_n),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.pready(pready),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status(rsp.status),
	.byte_offset(rsp.byte_offset),
	.level_width(rsp.level_width),
	.level_height(rsp.level_height),
	.level_depth(rsp.level_depth),
	.row_pitch(rsp.row_pitch),
	.plane_pitch(rsp.plane_pitch),
	.level_bytes(rsp.level_bytes),
	.image_bytes(rsp.image_bytes)
);
